### sv/cwss_pkg.sv
`default_nettype none
package cwss_pkg;

	typedef enum logic [1:0] {
		CMD_SECOND = 2'd0,
		CMD_SCAN   = 2'd1,
		CMD_LOAD   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_VIEW   = 3'd0,
		REG_FORMAT = 3'd1,
		REG_STATUS = 3'd2,
		REG_YEAR   = 3'd3,
		REG_MONTH  = 3'd4,
		REG_DAY    = 3'd5
	} reg_idx_t;

	localparam int CFG_W = 14;
	localparam int IDX_W = 3;

	localparam logic [6:0] SEC_LIMIT  = 7'd60;
	localparam logic [6:0] MIN_LIMIT  = 7'd60;
	localparam logic [5:0] HOUR_LIMIT = 6'd24;
	localparam logic [4:0] HALF_DAY   = 5'd12;

	localparam logic [7:0] SEG_DASH       = 8'hBF;
	localparam logic [7:0] SEG_POINT_MASK = 8'h7F;

	localparam logic [7:0] DIGIT_PATTERN [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
		8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
	};

	// floor(y/100) = (y * 20972) >> 21, exact for y < 43690
	localparam logic [14:0] RECIP_100 = 15'd20972;
	// floor(v/10) = (v * 205) >> 11, exact for v < 1024
	localparam logic [7:0]  RECIP_10  = 8'd205;

	typedef struct packed {
		logic [1:0] command;
		logic [4:0] load_hours;
		logic [5:0] load_minutes;
		logic [5:0] load_seconds;
		logic       point_off;
	} in_t;

	typedef struct packed {
		logic [7:0] digit_select;
		logic [7:0] segments;
		logic       display_valid;
		logic [4:0] hours_now;
		logic [5:0] minutes_now;
		logic [5:0] seconds_now;
	} out_t;

	typedef struct packed {
		logic       display_view;
		logic       hour_format_24;
		logic [1:0] display_status;
		logic [7:0] year_hi;
		logic [6:0] year_lo;
		logic [3:0] month_value;
		logic [4:0] day_value;
	} cfg_t;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} tod_t;

	function automatic logic [4:0] div10(input logic [7:0] v);
		logic [15:0] p;
		p = v * RECIP_10;
		return p[15:11];
	endfunction

	function automatic logic [3:0] mod10(input logic [7:0] v);
		logic [4:0] q;
		logic [7:0] r;
		q = div10(v);
		r = v - 8'(q) * 8'd10;
		return r[3:0];
	endfunction

	function automatic logic [7:0] seg_of(input logic [4:0] d);
		logic [4:0] r;
		r = (d >= 5'd10) ? d - 5'd10 : d;
		return DIGIT_PATTERN[r[3:0]];
	endfunction

endpackage
`default_nettype wire

### sv/clock_with_seven_segment_scan_top.sv
`default_nettype none
// channel | handshake               | payload
// in      | in_valid / in_stall     | in_data   (cwss_pkg::in_t)
// out     | out_valid / out_stall   | out_data  (cwss_pkg::out_t)
// cfg     | cfg_we                  | cfg_index, cfg_data
//
// One request per cycle while in_stall is low. Time and scan positions
// update at the accept edge; each result is registered in the result
// register, or in the one-entry skid stage while the output stalls.
// in_stall rises only while the skid stage holds a request.
// Reset clears time, scan positions and handshake state; config takes
// its defaults (time view, 24-hour, scanning, 2000-01-01).
module clock_with_seven_segment_scan_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire cwss_pkg::in_t              in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output cwss_pkg::out_t                  out_data,
	input  wire logic                       cfg_we,
	input  wire logic [cwss_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [cwss_pkg::CFG_W-1:0] cfg_data
);

	cwss_pkg::cfg_t cfg;
	cwss_pkg::tod_t tod;
	cwss_pkg::tod_t tod_next;
	cwss_pkg::out_t res;
	logic           acc;
	logic           scan;
	logic [2:0]     time_pos_q;
	logic [2:0]     date_pos_q;
	logic [2:0]     pos;
	logic [7:0]     seg;

	assign acc  = in_valid && !in_stall;
	assign scan = (in_data.command == cwss_pkg::CMD_SCAN) && !cfg.display_status[1];
	assign pos  = cfg.display_view ? time_pos_q : date_pos_q;

	cwss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cwss_time u_time (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (acc),
		.req      (in_data),
		.tod      (tod),
		.tod_next (tod_next)
	);

	cwss_disp u_disp (
		.cfg       (cfg),
		.tod       (tod),
		.pos       (pos),
		.point_off (in_data.point_off),
		.segments  (seg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_pos_q <= '0;
			date_pos_q <= '0;
		end else if (acc && scan) begin
			if (cfg.display_view) begin
				time_pos_q <= time_pos_q + 3'd1;
			end else begin
				date_pos_q <= date_pos_q + 3'd1;
			end
		end
	end

	always_comb begin
		res.digit_select  = scan ? 8'(1) << pos : 8'd0;
		res.segments      = scan ? seg : 8'd0;
		res.display_valid = scan;
		res.hours_now     = tod_next.hours;
		res.minutes_now   = tod_next.minutes;
		res.seconds_now   = tod_next.seconds;
	end

	cwss_oskid u_oskid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.display_valid |-> $onehot(out_data.digit_select))
		else $error("digit select not one-hot on a drive");

	a_no_drive_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.display_valid |->
			out_data.digit_select == 8'd0 && out_data.segments == 8'd0)
		else $error("drive fields set without a drive");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && scan) |=> $stable(time_pos_q) && $stable(date_pos_q))
		else $error("scan position moved without a scan");

endmodule
`default_nettype wire

### sv/cwss_cfg.sv
`default_nettype none
module cwss_cfg (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [cwss_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [cwss_pkg::CFG_W-1:0] cfg_data,
	output cwss_pkg::cfg_t                cfg
);

	cwss_pkg::cfg_t cfg_q;
	logic [28:0]    prod;
	logic [7:0]     hi;
	logic [13:0]    lo;

	// year kept split as hundreds and remainder
	always_comb begin
		prod = cfg_data * cwss_pkg::RECIP_100;
		hi   = prod[28:21];
		lo   = cfg_data - 14'(hi) * 14'd100;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_view   <= 1'b1;
			cfg_q.hour_format_24 <= 1'b1;
			cfg_q.display_status <= 2'd0;
			cfg_q.year_hi        <= 8'd20;
			cfg_q.year_lo        <= 7'd0;
			cfg_q.month_value    <= 4'd1;
			cfg_q.day_value      <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cwss_pkg::REG_VIEW:   cfg_q.display_view   <= cfg_data[0];
				cwss_pkg::REG_FORMAT: cfg_q.hour_format_24 <= cfg_data[0];
				cwss_pkg::REG_STATUS: cfg_q.display_status <= cfg_data[1:0];
				cwss_pkg::REG_YEAR: begin
					cfg_q.year_hi <= hi;
					cfg_q.year_lo <= lo[6:0];
				end
				cwss_pkg::REG_MONTH:  cfg_q.month_value    <= cfg_data[3:0];
				cwss_pkg::REG_DAY:    cfg_q.day_value      <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### sv/cwss_time.sv
`default_nettype none
module cwss_time (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire cwss_pkg::in_t  req,
	output cwss_pkg::tod_t      tod,
	output cwss_pkg::tod_t      tod_next
);

	cwss_pkg::tod_t tod_q;
	logic [6:0]     sec_inc;
	logic [6:0]     min_inc;
	logic [5:0]     hour_inc;

	always_comb begin
		sec_inc  = {1'b0, tod_q.seconds} + 7'd1;
		min_inc  = {1'b0, tod_q.minutes} + 7'd1;
		hour_inc = {1'b0, tod_q.hours} + 6'd1;
		tod_next = tod_q;
		unique case (req.command)
			cwss_pkg::CMD_SECOND: begin
				if (sec_inc >= cwss_pkg::SEC_LIMIT) begin
					tod_next.seconds = '0;
					if (min_inc >= cwss_pkg::MIN_LIMIT) begin
						tod_next.minutes = '0;
						tod_next.hours   = (hour_inc >= cwss_pkg::HOUR_LIMIT) ?
							5'd0 : hour_inc[4:0];
					end else begin
						tod_next.minutes = min_inc[5:0];
					end
				end else begin
					tod_next.seconds = sec_inc[5:0];
				end
			end
			cwss_pkg::CMD_LOAD: begin
				tod_next.hours   = req.load_hours;
				tod_next.minutes = req.load_minutes;
				tod_next.seconds = req.load_seconds;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tod_q <= '0;
		end else if (accept) begin
			tod_q <= tod_next;
		end
	end

	assign tod = tod_q;

endmodule
`default_nettype wire

### sv/cwss_disp.sv
`default_nettype none
module cwss_disp (
	input  wire cwss_pkg::cfg_t cfg,
	input  wire cwss_pkg::tod_t tod,
	input  wire logic [2:0]     pos,
	input  wire logic           point_off,
	output logic [7:0]          segments
);

	logic [4:0] h;
	logic [7:0] t_seg;
	logic [7:0] d_seg;

	always_comb begin
		h = tod.hours;
		if (!cfg.hour_format_24 && h > cwss_pkg::HALF_DAY) begin
			h = h - cwss_pkg::HALF_DAY;
		end
		unique case (pos)
			3'd0: t_seg = cwss_pkg::seg_of(cwss_pkg::div10({3'd0, h}));
			3'd1: t_seg = cwss_pkg::seg_of({1'b0, cwss_pkg::mod10({3'd0, h})});
			3'd2: t_seg = cwss_pkg::SEG_DASH;
			3'd3: t_seg = cwss_pkg::seg_of(cwss_pkg::div10({2'd0, tod.minutes}));
			3'd4: t_seg = cwss_pkg::seg_of({1'b0, cwss_pkg::mod10({2'd0, tod.minutes})});
			3'd5: t_seg = cwss_pkg::SEG_DASH;
			3'd6: t_seg = cwss_pkg::seg_of(cwss_pkg::div10({2'd0, tod.seconds}));
			default: begin
				t_seg = cwss_pkg::seg_of({1'b0, cwss_pkg::mod10({2'd0, tod.seconds})});
				if (!point_off) begin
					t_seg = t_seg & cwss_pkg::SEG_POINT_MASK;
				end
			end
		endcase
		unique case (pos)
			3'd0: d_seg = cwss_pkg::seg_of(cwss_pkg::div10(cfg.year_hi));
			3'd1: d_seg = cwss_pkg::seg_of({1'b0, cwss_pkg::mod10(cfg.year_hi)});
			3'd2: d_seg = cwss_pkg::seg_of(cwss_pkg::div10({1'b0, cfg.year_lo}));
			3'd3: d_seg = cwss_pkg::seg_of({1'b0, cwss_pkg::mod10({1'b0, cfg.year_lo})});
			3'd4: d_seg = cwss_pkg::seg_of(cwss_pkg::div10({4'd0, cfg.month_value}));
			3'd5: d_seg = cwss_pkg::seg_of({1'b0,
				cwss_pkg::mod10({4'd0, cfg.month_value})});
			3'd6: d_seg = cwss_pkg::seg_of(cwss_pkg::div10({3'd0, cfg.day_value}));
			default: d_seg = cwss_pkg::seg_of({1'b0,
				cwss_pkg::mod10({3'd0, cfg.day_value})});
		endcase
		segments = cfg.display_view ? t_seg : d_seg;
	end

endmodule
`default_nettype wire

### sv/cwss_oskid.sv
`default_nettype none
module cwss_oskid (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire cwss_pkg::out_t in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output cwss_pkg::out_t      out_data
);

	logic           out_valid_q;
	logic           skid_valid_q;
	cwss_pkg::out_t out_q;
	cwss_pkg::out_t skid_q;
	logic           acc;
	logic           take;

	assign in_stall = skid_valid_q;
	assign acc      = in_valid && !skid_valid_q;
	assign take     = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (!out_valid_q || take) begin
				out_q <= in_data;
			end else begin
				skid_q <= in_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a request while output is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && take |=> !skid_valid_q && out_valid_q && out_q == $past(skid_q))
		else $error("skid request not moved to output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled result changed");

endmodule
`default_nettype wire
